FILE: rtl/fpba_pkg.sv
// ============================================================================
// fpba_pkg: shared types and constants of the fit-policy block allocator
// Word layouts, register indexes, policy codes and controller states.
// ============================================================================
package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = 4;   // block_index field width, covers NUM_BLOCKS
    localparam int CNT_BITS   = 5;   // blocks_in_use register width
    localparam int POL_BITS   = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCKS_IN_USE = 2'd1;

    // policy codes
    localparam logic [POL_BITS-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_BITS-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_BITS-1:0] POL_WORST = 2'd2;

    localparam logic [POL_BITS-1:0] POL_RESET    = POL_FIRST;
    localparam logic [CNT_BITS-1:0] BLOCKS_RESET = CNT_BITS'(NUM_BLOCKS);

    // command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [IDX_BITS-1:0]  block_index;
        logic [SIZE_BITS-1:0] size;
    } in_word_t;

    typedef struct packed {
        logic                 granted;
        logic [IDX_BITS-1:0]  chosen_block;
        logic [SIZE_BITS-1:0] remaining;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // write a loaded size into the table
        logic start;   // latch a request and clear the search
        logic scan;    // read the next entry
        logic finish;  // write back and load the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bypass;     // request is refused without a search
        logic scan_last;  // entry being read is the last one searched
        logic out_free;   // output register can take a word this cycle
    } sts_t;

endpackage

FILE: rtl/fit_policy_block_allocator.sv
// ============================================================================
// fit_policy_block_allocator: first, best and worst fit block allocator
// Free-size table with a sequenced scan picking a block for each request.
// ============================================================================
// Usage:
//   in channel (in_valid/in_ready/in_word): a load word writes one block's
//   free size and yields no result; a request word asks for a block.
//   out channel (out_valid/out_ready/out_word): one word per request with
//   the grant flag, the chosen block and the size left in it.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
//   fit policy, index 1 the number of blocks searched. Always ready; write
//   only while the block is idle.
// Sequence:
//   A load is written while idle. A request reads the table one entry per cycle
//   through its single read port: the scan state reads each block searched,
//   the drain state does the last compare, the write state does the
//   write-back, and only then does idle accept the next word. A refused request
//   that needs no search (policy code three, zero blocks) goes from idle
//   straight to the write state.
// Reset: policy first fit, sixteen blocks searched; table contents are
//   undefined until loaded. No result is pending after reset.
// Stall: the result sits in an output register. The next word is accepted
//   while it waits; a following request holds at write-back until the
//   output register is taken.
// ============================================================================
module fit_policy_block_allocator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  fpba_pkg::in_word_t                    in_word,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output fpba_pkg::out_word_t                   out_word,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [fpba_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    fpba_pkg::cmd_t cmd;
    fpba_pkg::sts_t sts;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    fpba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_word.cmd),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fpba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cfg_wr    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

FILE: rtl/fpba_ctrl.sv
// ============================================================================
// fpba_ctrl: allocator sequencer
// Accepts words, runs the table scan and hands off the write-back.
// ============================================================================
module fpba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  fpba_pkg::sts_t      sts,
    output fpba_pkg::cmd_t      cmd
);

    fpba_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                if (in_valid && (in_cmd == fpba_pkg::CMD_REQUEST))
                begin
                    state_next = sts.bypass ? fpba_pkg::ST_WRITE : fpba_pkg::ST_SCAN;
                end
            end
            fpba_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = fpba_pkg::ST_DRAIN;
                end
            end
            fpba_pkg::ST_DRAIN:
            begin
                state_next = fpba_pkg::ST_WRITE;
            end
            fpba_pkg::ST_WRITE:
            begin
                if (sts.out_free)
                begin
                    state_next = fpba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpba_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.load  = in_valid && (in_cmd == fpba_pkg::CMD_LOAD);
                cmd.start = in_valid && (in_cmd == fpba_pkg::CMD_REQUEST);
            end
            fpba_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            fpba_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            fpba_pkg::ST_WRITE:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/fpba_dp.sv
// ============================================================================
// fpba_dp: allocator datapath
// Free-size table, config registers, scan compare and output register.
// ============================================================================
module fpba_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fpba_pkg::in_word_t                    in_word,
    input  logic                                  cfg_wr,
    input  logic [fpba_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [fpba_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  fpba_pkg::cmd_t                        cmd,
    output fpba_pkg::sts_t                        sts,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output fpba_pkg::out_word_t                   out_word
);

    localparam int SB = fpba_pkg::SIZE_BITS;
    localparam int IB = fpba_pkg::IDX_BITS;
    localparam int CB = fpba_pkg::CNT_BITS;

    logic [SB-1:0] mem [fpba_pkg::NUM_BLOCKS];

    logic [fpba_pkg::POL_BITS-1:0] policy_reg;
    logic [CB-1:0]                 blocks_reg;

    logic [fpba_pkg::POL_BITS-1:0] req_pol_reg;
    logic [SB-1:0]                 req_size_reg;
    logic [IB-1:0]                 last_idx_reg;
    logic [IB-1:0]                 scan_idx_reg;
    logic                          rd_valid_reg;
    logic [IB-1:0]                 rd_idx_reg;
    logic [SB-1:0]                 rd_data_reg;
    logic                          found_reg;
    logic [IB-1:0]                 pick_reg;
    logic [SB-1:0]                 best_reg;

    logic                          out_valid_reg;
    fpba_pkg::out_word_t           out_word_reg;

    logic [CB-1:0] n_clamped;
    logic          hit;
    logic          take;
    logic [SB-1:0] rem;
    logic          wr_en;
    logic [IB-1:0] wr_addr;
    logic [SB-1:0] wr_data;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= fpba_pkg::POL_RESET;
            blocks_reg <= fpba_pkg::BLOCKS_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == fpba_pkg::CFG_FIT_POLICY)
            begin
                policy_reg <= cfg_data[fpba_pkg::POL_BITS-1:0];
            end
            else if (cfg_index == fpba_pkg::CFG_BLOCKS_IN_USE)
            begin
                blocks_reg <= cfg_data[CB-1:0];
            end
        end
    end

    assign n_clamped = (blocks_reg > CB'(fpba_pkg::NUM_BLOCKS)) ?
                       CB'(fpba_pkg::NUM_BLOCKS) : blocks_reg;

    // policy code three and an empty search are refused outright
    assign sts.bypass    = (policy_reg > fpba_pkg::POL_WORST) || (blocks_reg == '0);
    assign sts.scan_last = (scan_idx_reg == last_idx_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // compare of the entry read last cycle
    assign hit = rd_valid_reg && (rd_data_reg >= req_size_reg);
    always_comb
    begin
        take = 1'b0;
        if (hit)
        begin
            priority if (!found_reg)
                take = 1'b1;
            else if (req_pol_reg == fpba_pkg::POL_BEST)
                take = rd_data_reg < best_reg;
            else if (req_pol_reg == fpba_pkg::POL_WORST)
                take = rd_data_reg > best_reg;
            else
                take = 1'b0;
        end
    end

    assign rem = best_reg - req_size_reg;

    // single write port: loads in idle, write-back at finish
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = in_word.block_index;
        wr_data = in_word.size;
        if (cmd.load)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.finish && found_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pick_reg;
            wr_data = rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[scan_idx_reg];
    end

    // search control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            scan_idx_reg <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan;
            if (cmd.start)
            begin
                found_reg    <= 1'b0;
                scan_idx_reg <= '0;
            end
            else
            begin
                if (cmd.scan && !sts.scan_last)
                begin
                    scan_idx_reg <= scan_idx_reg + IB'(1);
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // search payload
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx_reg;
        if (cmd.start)
        begin
            req_pol_reg  <= policy_reg;
            req_size_reg <= in_word.size;
            last_idx_reg <= IB'(n_clamped - CB'(1));
        end
        if (take)
        begin
            pick_reg <= rd_idx_reg;
            best_reg <= rd_data_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_word_reg.granted      <= found_reg;
            out_word_reg.chosen_block <= found_reg ? pick_reg : '0;
            out_word_reg.remaining    <= found_reg ? rem : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
